### design/fhp_pkg.sv
package fhp_pkg;

    // Field and register widths
    localparam int unsigned HeatW      = 8;
    localparam int unsigned ColsCfgW   = 11;
    localparam int unsigned OffsetW    = 10;
    localparam int unsigned CfgDataW   = 11;
    localparam int unsigned CfgIndexW  = 1;
    // Five-neighbor sum, at most 5 * 255 = 1275
    localparam int unsigned SumW       = 11;

    // Geometry and register reset values
    localparam int unsigned MaxColsDefault = 1024;
    localparam int unsigned ColsReset      = 1024;
    localparam int unsigned OffsetReset    = 16;

    // Divide by 5 as multiply by 6554 / 2^15, exact for values below 1280
    localparam int unsigned RecipW   = 13;
    localparam logic [RecipW-1:0] DivRecip = 13'd6554;
    localparam int unsigned DivShift = 15;

    // Output queue
    localparam int unsigned OfifoDepth = 8;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_ACTIVE_COLS    = 1'b0,
        CFG_COOLING_OFFSET = 1'b1
    } t_cfg_index;

    // Neighbor sum of one visible pixel
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [SumW-1:0] sum;
    } t_sum_item;

    // Finished result
    typedef struct packed {
        logic             valid;
        logic             row_end;
        logic [HeatW-1:0] heat;
    } t_res_item;

endpackage

### design/fire_heat_propagation_top.sv
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_heat_in[7:0], i_frame_start
// output    o_valid / i_stall    o_heat_out[7:0], o_row_end
// config    i_cfg_we             i_cfg_index[0:0], i_cfg_data[10:0]
//
// One pixel per clock while o_stall is low; a result passes the line store
// read, neighbor sum, cool and divide, and output queue before it leaves.
// Pace is set by the two-read, one-write line store: one read-modify-write
// per pixel, with the previous pixel's write forwarded to the next read.
// Fuel rows produce no result. Reset is synchronous; the line stores keep
// no reset, and the fuel rows write them before any result uses them. o_stall
// rises once the output queue plus the pixels in flight would fill it.
module fire_heat_propagation_top
    import fhp_pkg::*;
#(
    parameter int unsigned MAX_COLS = MaxColsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [HeatW-1:0]     i_heat_in,
    input  logic                 i_frame_start,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [HeatW-1:0]     o_heat_out,
    output logic                 o_row_end,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    localparam int unsigned CntW = $clog2(OfifoDepth + 1);
    localparam int unsigned OccW = CntW + 2;

    logic [ColsCfgW-1:0] r_active_cols;
    logic [OffsetW-1:0]  r_cooling_offset;
    logic                accept;
    logic                s1_busy;
    t_sum_item           sum_item;
    t_res_item           res_item;
    logic [CntW-1:0]     q_count;
    logic [OccW-1:0]     occ;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cols    <= ColsCfgW'(ColsReset);
            r_cooling_offset <= OffsetW'(OffsetReset);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ACTIVE_COLS:    r_active_cols    <= i_cfg_data[ColsCfgW-1:0];
                CFG_COOLING_OFFSET: r_cooling_offset <= i_cfg_data[OffsetW-1:0];
            endcase
        end
    end

    // Queue space reserved for every result still in the pipe
    assign occ = OccW'(q_count) + OccW'(s1_busy) + OccW'(sum_item.valid)
               + OccW'(res_item.valid);
    assign o_stall = (occ >= OccW'(OfifoDepth));
    assign accept  = i_valid && !o_stall;

    fhp_line #(
        .MaxCols (MAX_COLS)
    ) u_line (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_heat        (i_heat_in),
        .i_frame_start (i_frame_start),
        .i_active_cols (r_active_cols),
        .o_s1_busy     (s1_busy),
        .o_sum         (sum_item)
    );

    fhp_cool u_cool (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sum            (sum_item),
        .i_cooling_offset (r_cooling_offset),
        .o_res            (res_item)
    );

    fhp_ofifo u_ofifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_item),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_heat_out (o_heat_out),
        .o_row_end  (o_row_end),
        .o_count    (q_count)
    );

endmodule

### design/fhp_ram.sv
module fhp_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16,
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr_a,
    input  logic [AddrW-1:0] i_raddr_b,
    output logic [Width-1:0] o_rdata_a,
    output logic [Width-1:0] o_rdata_b
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata_a;
    logic [Width-1:0] r_rdata_b;

    // One write port, two registered read ports (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### design/fhp_line.sv
module fhp_line
    import fhp_pkg::*;
#(
    parameter int unsigned MaxCols = MaxColsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [HeatW-1:0]    i_heat,
    input  logic                i_frame_start,
    input  logic [ColsCfgW-1:0] i_active_cols,
    output logic                o_s1_busy,
    output t_sum_item           o_sum
);

    localparam int unsigned AddrW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
    localparam int unsigned ColsW = (AddrW + 1 > ColsCfgW) ? AddrW + 1 : ColsCfgW;
    localparam logic [ColsW-1:0] MaxColsV = ColsW'(MaxCols);
    localparam int unsigned WordW = 2 * HeatW;

    // Column and row tracking
    logic [AddrW-1:0] r_col;
    logic [1:0]       r_rows;

    // Stage 1: read data arrives, sum and write-back
    logic             r_s1_valid;
    logic [AddrW-1:0] r_s1_x;
    logic             r_s1_first;
    logic             r_s1_last;
    logic             r_s1_emit;
    logic [HeatW-1:0] r_s1_heat;
    logic             r_fwd_a;
    logic             r_fwd_b;
    logic [WordW-1:0] r_fwd_data;
    logic [HeatW-1:0] r_held_b;
    logic [HeatW-1:0] r_held_t;
    t_sum_item        r_sum;

    logic [ColsW-1:0] cols_ext;
    logic [ColsW-1:0] cols_eff;
    logic [AddrW-1:0] cols_m1;
    logic [AddrW-1:0] cur_col;
    logic [1:0]       cur_rows;
    logic             last;
    logic [AddrW-1:0] x;
    logic [AddrW-1:0] xr;
    logic [WordW-1:0] rd_a;
    logic [WordW-1:0] rd_b;
    logic [WordW-1:0] word_c;
    logic [WordW-1:0] word_r;
    logic [HeatW-1:0] b_c, t_c, b_r, t_r, b_l, t_l;
    logic [SumW-1:0]  sum;
    logic [WordW-1:0] wdata;

    // Stage 0: column position and read addresses
    always_comb begin
        cols_ext = ColsW'(i_active_cols);
        if (cols_ext == '0) begin
            cols_eff = ColsW'(1);
        end else if (cols_ext > MaxColsV) begin
            cols_eff = MaxColsV;
        end else begin
            cols_eff = cols_ext;
        end
        cols_m1  = AddrW'(cols_eff - ColsW'(1));
        cur_col  = i_frame_start ? '0 : r_col;
        cur_rows = i_frame_start ? 2'd0 : r_rows;
        last     = (cur_col >= cols_m1);
        x        = last ? cols_m1 : cur_col;
        xr       = last ? x : x + AddrW'(1);
    end

    // Line stores: word is {row below, two rows below}
    fhp_ram #(
        .Width (WordW),
        .Depth (MaxCols)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (r_s1_valid),
        .i_waddr   (r_s1_x),
        .i_wdata   (wdata),
        .i_re      (i_accept),
        .i_raddr_a (x),
        .i_raddr_b (xr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Stage 1: forward the write of the previous pixel, clamp edges, sum
    always_comb begin
        word_c = r_fwd_a ? r_fwd_data : rd_a;
        word_r = r_fwd_b ? r_fwd_data : rd_b;
        b_c    = word_c[WordW-1:HeatW];
        t_c    = word_c[HeatW-1:0];
        b_r    = r_s1_last ? b_c : word_r[WordW-1:HeatW];
        t_r    = r_s1_last ? t_c : word_r[HeatW-1:0];
        b_l    = r_s1_first ? b_c : r_held_b;
        t_l    = r_s1_first ? t_c : r_held_t;
        sum    = SumW'(b_l) + SumW'(b_c) + SumW'(b_r) + SumW'(t_l) + SumW'(t_r);
        wdata  = {r_s1_heat, b_c};
    end

    // Control state and sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_rows     <= 2'd0;
            r_s1_valid <= 1'b0;
            r_held_b   <= '0;
            r_held_t   <= '0;
            r_sum.valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= last ? '0 : cur_col + AddrW'(1);
                if (last && cur_rows != 2'd2) begin
                    r_rows <= cur_rows + 2'd1;
                end else begin
                    r_rows <= cur_rows;
                end
            end
            r_s1_valid <= i_accept;
            if (r_s1_valid) begin
                r_held_b <= b_c;
                r_held_t <= t_c;
            end
            r_sum.valid <= r_s1_valid && r_s1_emit;
        end
        r_sum.sum  <= sum;
        r_sum.last <= r_s1_last;
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        r_s1_x     <= x;
        r_s1_first <= (x == '0);
        r_s1_last  <= last;
        r_s1_emit  <= (cur_rows == 2'd2);
        r_s1_heat  <= i_heat;
        r_fwd_a    <= r_s1_valid && (r_s1_x == x);
        r_fwd_b    <= r_s1_valid && (r_s1_x == xr);
        r_fwd_data <= wdata;
    end

    assign o_s1_busy = r_s1_valid && r_s1_emit;
    assign o_sum     = r_sum;

endmodule

### design/fhp_cool.sv
module fhp_cool
    import fhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sum_item          i_sum,
    input  logic [OffsetW-1:0] i_cooling_offset,
    output t_res_item          o_res
);

    localparam int unsigned ProdW = SumW + RecipW;

    t_res_item          r_res;
    logic [OffsetW-1:0] off;
    logic [SumW-1:0]    diff;
    logic [ProdW-1:0]   prod;
    logic [HeatW-1:0]   heat;

    // Offset, subtract and divide by five through the reciprocal
    always_comb begin
        off  = (i_cooling_offset == '0) ? OffsetW'(1) : i_cooling_offset;
        diff = i_sum.sum - SumW'(off);
        prod = ProdW'(diff) * ProdW'(DivRecip);
        heat = (i_sum.sum > SumW'(off)) ? prod[DivShift +: HeatW] : '0;
    end

    // Result register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= i_sum.valid;
        end
        r_res.row_end <= i_sum.last;
        r_res.heat    <= heat;
    end

    assign o_res = r_res;

endmodule

### design/fhp_ofifo.sv
module fhp_ofifo
    import fhp_pkg::*;
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_res_item                            i_push,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [HeatW-1:0]                     o_heat_out,
    output logic                                 o_row_end,
    output logic [$clog2(OfifoDepth + 1)-1:0]    o_count
);

    localparam int unsigned PtrW = $clog2(OfifoDepth);
    localparam int unsigned CntW = $clog2(OfifoDepth + 1);
    localparam int unsigned EntW = HeatW + 1;

    logic [EntW-1:0] r_data [OfifoDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            pop;

    assign pop = o_valid && !i_stall;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == PtrW'(OfifoDepth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(OfifoDepth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            case ({i_push.valid, pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data[r_wr] <= {i_push.row_end, i_push.heat};
        end
    end

    assign o_valid    = (r_count != '0);
    assign o_heat_out = r_data[r_rd][HeatW-1:0];
    assign o_row_end  = r_data[r_rd][HeatW];
    assign o_count    = r_count;

endmodule

### design/fhp_checker.sv
module fhp_checker
    import fhp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [HeatW-1:0]     o_heat_out,
    input logic                 o_row_end
);

    localparam int unsigned PendW = 16;

    logic [PendW-1:0] r_pending;
    logic             r_sat;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Items taken minus results delivered; checking stops if it saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_sat     <= 1'b0;
        end else begin
            case ({in_acc, out_acc})
                2'b10: begin
                    if (r_pending == '1) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_pending <= r_pending + PendW'(1);
                    end
                end
                2'b01:   r_pending <= r_pending - PendW'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

    // A result is never delivered without an earlier item behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !r_sat |-> r_pending != '0)
        else $error("result delivered with no item outstanding");

    // Reset empties the queue and opens the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped under stall");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_heat_out) && $stable(o_row_end))
        else $error("output payload changed under stall");

endmodule

bind fire_heat_propagation_top fhp_checker u_fhp_checker (.*);
